// File: rtl/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg: shared types and constants of the pausable countdown timer
// Command and result layouts, mode, opcode and status codes, bus widths.
// ----------------------------------------------------------------------------
package pct_pkg;

   localparam int TIME_BITS_DEFAULT = 48;
   localparam int NOW_BITS          = 48;
   localparam int OWNER_BITS        = 16;
   localparam int DUR_BITS          = 32;
   localparam int COUNT_BITS        = 32;
   localparam int CSR_COUNT         = 2;
   localparam int CSR_INDEX_BITS    = 1;

   localparam logic [DUR_BITS-1:0] MIN_DURATION_RESET = 32'd1;
   localparam logic [DUR_BITS-1:0] MAX_DURATION_RESET = 32'hFFFF_FFFF;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MIN_DURATION = 1'b0,
      CSR_MAX_DURATION = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_ADVANCE = 3'd0,
      OP_START   = 3'd1,
      OP_PAUSE   = 3'd2,
      OP_RESUME  = 3'd3,
      OP_SET_REM = 3'd4,
      OP_ACK     = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      MODE_READY   = 2'd0,
      MODE_RUNNING = 2'd1,
      MODE_PAUSED  = 2'd2,
      MODE_EXPIRED = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_OWNER    = 3'd1,
      ST_BAD_STATE    = 3'd2,
      ST_BAD_DURATION = 3'd3,
      ST_NOT_OWNER    = 3'd4,
      ST_REGRESSED    = 3'd5
   } status_type;

   // Command layout, last field in the lowest bits.
   typedef struct packed {
      logic [DUR_BITS-1:0]   duration_ms;
      logic [OWNER_BITS-1:0] owner_id;
      logic [NOW_BITS-1:0]   now_ms;
      logic [2:0]            op;
   } cmd_type;

   // Result layout, last field in the lowest bits.
   typedef struct packed {
      logic [COUNT_BITS-1:0] expiry_count;
      logic [DUR_BITS-1:0]   remaining_ms;
      mode_type              timer_state;
      logic                  expired_now;
      status_type            status;
   } rsp_type;

   localparam int REQ_BITS       = $bits(cmd_type);
   localparam int REQ_TDATA_BITS = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS       = $bits(rsp_type);
   localparam int RSP_TDATA_BITS = ((RSP_BITS + 7) / 8) * 8;

endpackage

// File: rtl/pct_cmd_stage.sv
// ----------------------------------------------------------------------------
// pct_cmd_stage: command input register
// Captures one command transaction and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module pct_cmd_stage
   import pct_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   input  logic                      advance,
   output logic                      cmd_valid,
   output cmd_type                   cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
      cmd_in   = take ? cmd_type'(req_tdata[REQ_BITS-1:0]) : cmd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

// File: rtl/pct_engine.sv
// ----------------------------------------------------------------------------
// pct_engine: timer state and command evaluation
// Checks one command against the timer state and updates the state.
// ----------------------------------------------------------------------------
module pct_engine
   import pct_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  cmd_type             cmd,
   input  logic [DUR_BITS-1:0] min_duration,
   input  logic [DUR_BITS-1:0] max_duration,
   output rsp_type             rsp
);

   mode_type                mode_ff, mode_in;
   logic [OWNER_BITS-1:0]   owner_ff, owner_in;
   logic [DUR_BITS-1:0]     config_dur_ff, config_dur_in;
   logic [DUR_BITS-1:0]     remaining_ff, remaining_in;
   logic [TIME_BITS-1:0]    deadline_ff, deadline_in;
   logic [TIME_BITS-1:0]    cur_time_ff, cur_time_in;
   logic                    time_known_ff, time_known_in;
   logic [COUNT_BITS-1:0]   generation_ff, generation_in;

   logic [TIME_BITS-1:0]    now_t;
   logic                    dur_ok;
   logic                    owner_match;
   logic [DUR_BITS-1:0]     arm_rem;
   logic [TIME_BITS:0]      arm_sum;
   logic [TIME_BITS-1:0]    arm_deadline;
   logic                    regressed;
   logic                    before_deadline;
   logic [TIME_BITS-1:0]    time_left;
   status_type              status;
   logic                    fired;

   assign now_t       = TIME_BITS'(cmd.now_ms);
   assign dur_ok      = (cmd.duration_ms >= min_duration) && (cmd.duration_ms <= max_duration);
   assign owner_match = (cmd.owner_id != '0) && (cmd.owner_id == owner_ff);

   // A start arms with the new duration, a resume with what is left.
   assign arm_rem      = (op_type'(cmd.op) == OP_START) ? cmd.duration_ms : remaining_ff;
   assign arm_sum      = {1'b0, cur_time_ff} + (TIME_BITS + 1)'(arm_rem);
   assign arm_deadline = arm_sum[TIME_BITS] ? '1 : arm_sum[TIME_BITS-1:0];

   assign regressed       = time_known_ff && (now_t < cur_time_ff);
   assign before_deadline = now_t < deadline_ff;
   assign time_left       = deadline_ff - now_t;

   always_comb begin
      mode_in       = mode_ff;
      owner_in      = owner_ff;
      config_dur_in = config_dur_ff;
      remaining_in  = remaining_ff;
      deadline_in   = deadline_ff;
      cur_time_in   = cur_time_ff;
      time_known_in = time_known_ff;
      generation_in = generation_ff;
      status        = ST_OK;
      fired         = 1'b0;

      case (op_type'(cmd.op))
         OP_ADVANCE: begin
            if (regressed) begin
               status = ST_REGRESSED;
            end else begin
               cur_time_in   = now_t;
               time_known_in = 1'b1;
               if (mode_ff == MODE_RUNNING) begin
                  if (before_deadline) begin
                     remaining_in = time_left[DUR_BITS-1:0];
                  end else begin
                     remaining_in  = '0;
                     mode_in       = MODE_EXPIRED;
                     generation_in = generation_ff + 1'b1;
                     fired         = 1'b1;
                  end
               end
            end
         end
         OP_START: begin
            if (cmd.owner_id == '0) begin
               status = ST_BAD_OWNER;
            end else if (mode_ff != MODE_READY) begin
               status = ST_BAD_STATE;
            end else if (!dur_ok) begin
               status = ST_BAD_DURATION;
            end else begin
               config_dur_in = cmd.duration_ms;
               remaining_in  = cmd.duration_ms;
               owner_in      = cmd.owner_id;
               mode_in       = MODE_RUNNING;
               deadline_in   = arm_deadline;
            end
         end
         OP_PAUSE: begin
            if (mode_ff != MODE_RUNNING) begin
               status = ST_BAD_STATE;
            end else if (!owner_match) begin
               status = ST_NOT_OWNER;
            end else begin
               mode_in = MODE_PAUSED;
            end
         end
         OP_RESUME: begin
            if (mode_ff != MODE_PAUSED) begin
               status = ST_BAD_STATE;
            end else if (!owner_match) begin
               status = ST_NOT_OWNER;
            end else begin
               mode_in     = MODE_RUNNING;
               deadline_in = arm_deadline;
            end
         end
         OP_SET_REM: begin
            if (mode_ff != MODE_PAUSED) begin
               status = ST_BAD_STATE;
            end else if (!owner_match) begin
               status = ST_NOT_OWNER;
            end else if (!dur_ok) begin
               status = ST_BAD_DURATION;
            end else begin
               config_dur_in = cmd.duration_ms;
               remaining_in  = cmd.duration_ms;
            end
         end
         OP_ACK: begin
            if (mode_ff != MODE_EXPIRED) begin
               status = ST_BAD_STATE;
            end else begin
               mode_in      = MODE_READY;
               remaining_in = config_dur_ff;
               owner_in     = '0;
            end
         end
         default: begin
            status = ST_BAD_STATE;
         end
      endcase

      rsp.status       = status;
      rsp.expired_now  = fired;
      rsp.timer_state  = mode_in;
      rsp.remaining_ms = remaining_in;
      rsp.expiry_count = generation_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_READY;
         owner_ff      <= '0;
         config_dur_ff <= '0;
         remaining_ff  <= '0;
         deadline_ff   <= '0;
         cur_time_ff   <= '0;
         time_known_ff <= 1'b0;
         generation_ff <= '0;
      end else if (fire) begin
         mode_ff       <= mode_in;
         owner_ff      <= owner_in;
         config_dur_ff <= config_dur_in;
         remaining_ff  <= remaining_in;
         deadline_ff   <= deadline_in;
         cur_time_ff   <= cur_time_in;
         time_known_ff <= time_known_in;
         generation_ff <= generation_in;
      end
   end

endmodule

// File: rtl/pct_rsp_stage.sv
// ----------------------------------------------------------------------------
// pct_rsp_stage: result output register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module pct_rsp_stage
   import pct_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  rsp_type                   rsp,
   output logic                      free,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata
);

   logic    valid_ff, valid_in;
   rsp_type rsp_ff, rsp_in;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
      rsp_in   = load ? rsp : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_BITS - RSP_BITS){1'b0}}, rsp_ff};

endmodule

// File: rtl/pausable_countdown_timer.sv
// ----------------------------------------------------------------------------
// pausable_countdown_timer: one-shot countdown timer with an owner
// Command in, status and timer state out, one result per command.
// ----------------------------------------------------------------------------
// Each command transaction on the req_ channel (advance time, start, pause,
// resume, set remaining, acknowledge) produces exactly one result transaction
// on the rsp_ channel, in order. A command is taken into the command register,
// evaluated there against the timer state once the output register is free,
// and its result lands in the output register while the state updates on the
// same edge. One command per cycle is sustained while the receiver keeps up,
// since the state feedback loop holds no register beyond the state itself.
// When the receiver stalls, the output register holds its result, one more
// command waits in the command register, and then req_tready drops until
// rsp_tready returns. The csr_ port writes the duration limits; it is meant to
// be used only while no command is in flight. Synchronous reset empties both
// registers, returns the timer to ready with no owner, clears the time and
// the expiry count, and restores the limits to 1 and 0xFFFFFFFF.
// ----------------------------------------------------------------------------
module pausable_countdown_timer
   import pct_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // req_tdata, from bit 0: op, now_ms, owner_id, duration_ms, zero pad
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   // rsp_tdata, from bit 0: status, expired_now, timer_state, remaining_ms,
   // expiry_count, zero pad
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DUR_BITS-1:0]       csr_wdata
);

   logic [DUR_BITS-1:0] min_dur_ff, min_dur_in;
   logic [DUR_BITS-1:0] max_dur_ff, max_dur_in;
   logic                cmd_valid;
   cmd_type             cmd;
   rsp_type             rsp;
   logic                out_free;
   logic                fire;

   // The engine fires when a command is pending and the output slot is open.
   assign fire = cmd_valid && out_free;

   always_comb begin
      min_dur_in = min_dur_ff;
      max_dur_in = max_dur_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_DURATION: min_dur_in = csr_wdata;
            CSR_MAX_DURATION: max_dur_in = csr_wdata;
            default: begin
               min_dur_in = min_dur_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dur_ff <= MIN_DURATION_RESET;
         max_dur_ff <= MAX_DURATION_RESET;
      end else begin
         min_dur_ff <= min_dur_in;
         max_dur_ff <= max_dur_in;
      end
   end

   pct_cmd_stage u_cmd_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (fire),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd)
   );

   pct_engine #(
      .TIME_BITS (TIME_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .cmd          (cmd),
      .min_duration (min_dur_ff),
      .max_duration (max_dur_ff),
      .rsp          (rsp)
   );

   pct_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .rsp        (rsp),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: rtl/pct_checker.sv
// ----------------------------------------------------------------------------
// pct_checker: port-level checks for the countdown timer
// Watches the top-level ports and flags inconsistent results.
// ----------------------------------------------------------------------------
module pct_checker
   import pct_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [REQ_TDATA_BITS-1:0] req_tdata,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_TDATA_BITS-1:0] rsp_tdata
);

   rsp_type rsp_view;
   assign rsp_view = rsp_type'(rsp_tdata[RSP_BITS-1:0]);

   // No result may appear right out of reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // An expiry is always an accepted advance that leaves the timer expired.
   a_expiry_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_view.expired_now) |->
         (rsp_view.status == ST_OK && rsp_view.timer_state == MODE_EXPIRED &&
          rsp_view.remaining_ms == '0))
      else $error("expiry reported with inconsistent status or state");

   // An ownership failure only arises while the timer is running or paused.
   a_not_owner_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_view.status == ST_NOT_OWNER) |->
         (rsp_view.timer_state == MODE_RUNNING || rsp_view.timer_state == MODE_PAUSED))
      else $error("not-owner status outside running or paused");

   // A stalled result holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // A waiting command is held by the sender until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready) |=> (req_tvalid && $stable(req_tdata)))
      else $error("waiting command changed");

endmodule

bind pausable_countdown_timer pct_checker u_pct_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the pausable countdown timer
// Drives command transactions, predicts each result and compares it field by
// field, under several limit settings and several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;
   import pct_pkg::*;

   // Opcodes the block does not define; both must answer with a bad state.
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   // Top of the time range for the default time width.
   localparam logic [NOW_BITS-1:0] TIME_TOP = '1;

   // Cycles allowed after the last result for anything late to show up.
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PER_PHASE = 380;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [DUR_BITS-1:0]       csr_wdata  = '0;

   // Idle pattern of the two sides, in percent of cycles.
   int gap_pct   = 0;
   int stall_pct = 0;

   int cycle_count = 0;
   int mismatches  = 0;
   int sent_count  = 0;

   // Expected results, oldest first.
   rsp_type pending_results[$];
   rsp_type seen_rsp;
   rsp_type want_rsp;

   // Shadow of the timer state and of the duration limits.
   mode_type              timer_mode   = MODE_READY;
   logic [OWNER_BITS-1:0] timer_owner  = '0;
   logic [DUR_BITS-1:0]   set_duration = '0;
   logic [DUR_BITS-1:0]   time_left    = '0;
   logic [NOW_BITS-1:0]   deadline_ms  = '0;
   logic [NOW_BITS-1:0]   clock_ms     = '0;
   logic                  clock_seen   = 1'b0;
   logic [COUNT_BITS-1:0] expiry_total = '0;
   logic [DUR_BITS-1:0]   dur_floor    = MIN_DURATION_RESET;
   logic [DUR_BITS-1:0]   dur_ceiling  = MAX_DURATION_RESET;

   pausable_countdown_timer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Adds a delta to a time and clamps the sum at the top of the time range.
   function automatic logic [NOW_BITS-1:0] add_saturate(logic [NOW_BITS-1:0] base,
                                                         logic [DUR_BITS:0] delta);
      logic [NOW_BITS:0] sum;
      sum = {1'b0, base} + (NOW_BITS + 1)'(delta);
      return sum[NOW_BITS] ? TIME_TOP : sum[NOW_BITS-1:0];
   endfunction

   function automatic logic duration_in_range(logic [DUR_BITS-1:0] dur);
      return dur >= dur_floor && dur <= dur_ceiling;
   endfunction

   // Applies one command to the shadow state and returns the result that the
   // block must give for it. The checks run in the same order as the block's:
   // owner, mode, ownership, then duration.
   function automatic rsp_type timer_step(cmd_type c);
      rsp_type    r;
      status_type st;
      logic       fired;
      st    = ST_OK;
      fired = 1'b0;
      case (c.op)
         OP_ADVANCE: begin
            if (clock_seen && c.now_ms < clock_ms) begin
               st = ST_REGRESSED;
            end else begin
               clock_ms   = c.now_ms;
               clock_seen = 1'b1;
               if (timer_mode == MODE_RUNNING) begin
                  if (clock_ms < deadline_ms) begin
                     time_left = DUR_BITS'(deadline_ms - clock_ms);
                  end else begin
                     time_left    = '0;
                     timer_mode   = MODE_EXPIRED;
                     expiry_total = expiry_total + 1'b1;
                     fired        = 1'b1;
                  end
               end
            end
         end
         OP_START: begin
            if (c.owner_id == '0) begin
               st = ST_BAD_OWNER;
            end else if (timer_mode != MODE_READY) begin
               st = ST_BAD_STATE;
            end else if (!duration_in_range(c.duration_ms)) begin
               st = ST_BAD_DURATION;
            end else begin
               set_duration = c.duration_ms;
               time_left    = c.duration_ms;
               timer_owner  = c.owner_id;
               timer_mode   = MODE_RUNNING;
               deadline_ms  = add_saturate(clock_ms, {1'b0, time_left});
            end
         end
         OP_PAUSE: begin
            if (timer_mode != MODE_RUNNING) begin
               st = ST_BAD_STATE;
            end else if (c.owner_id == '0 || c.owner_id != timer_owner) begin
               st = ST_NOT_OWNER;
            end else begin
               timer_mode = MODE_PAUSED;
            end
         end
         OP_RESUME: begin
            if (timer_mode != MODE_PAUSED) begin
               st = ST_BAD_STATE;
            end else if (c.owner_id == '0 || c.owner_id != timer_owner) begin
               st = ST_NOT_OWNER;
            end else begin
               timer_mode  = MODE_RUNNING;
               deadline_ms = add_saturate(clock_ms, {1'b0, time_left});
            end
         end
         OP_SET_REM: begin
            if (timer_mode != MODE_PAUSED) begin
               st = ST_BAD_STATE;
            end else if (c.owner_id == '0 || c.owner_id != timer_owner) begin
               st = ST_NOT_OWNER;
            end else if (!duration_in_range(c.duration_ms)) begin
               st = ST_BAD_DURATION;
            end else begin
               set_duration = c.duration_ms;
               time_left    = c.duration_ms;
            end
         end
         OP_ACK: begin
            // Acknowledge looks at the mode only, not at the owner.
            if (timer_mode != MODE_EXPIRED) begin
               st = ST_BAD_STATE;
            end else begin
               timer_mode  = MODE_READY;
               time_left   = set_duration;
               timer_owner = '0;
            end
         end
         default: begin
            st = ST_BAD_STATE;
         end
      endcase
      r.status       = st;
      r.expired_now  = fired;
      r.timer_state  = timer_mode;
      r.remaining_ms = time_left;
      r.expiry_count = expiry_total;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------

   task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
      if (mismatches < 10) begin
         $display("mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
      end
      mismatches++;
   endtask

   // Every result transaction is matched against the oldest expectation.
   // Outputs are sampled at the edge, before the block updates them.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsp = rsp_type'(rsp_tdata[RSP_BITS-1:0]);
         if (pending_results.size() == 0) begin
            note_mismatch("result with nothing pending", '0, 64'(seen_rsp));
         end else begin
            want_rsp = pending_results.pop_front();
            if (seen_rsp.status !== want_rsp.status)
               note_mismatch("status", 64'(want_rsp.status), 64'(seen_rsp.status));
            if (seen_rsp.expired_now !== want_rsp.expired_now)
               note_mismatch("expired_now", 64'(want_rsp.expired_now),
                             64'(seen_rsp.expired_now));
            if (seen_rsp.timer_state !== want_rsp.timer_state)
               note_mismatch("timer_state", 64'(want_rsp.timer_state),
                             64'(seen_rsp.timer_state));
            if (seen_rsp.remaining_ms !== want_rsp.remaining_ms)
               note_mismatch("remaining_ms", 64'(want_rsp.remaining_ms),
                             64'(seen_rsp.remaining_ms));
            if (seen_rsp.expiry_count !== want_rsp.expiry_count)
               note_mismatch("expiry_count", 64'(want_rsp.expiry_count),
                             64'(seen_rsp.expiry_count));
         end
      end
   end

   // The receiver stalls at random in the current pattern.
   always @(posedge clock) begin
      rsp_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic logic [NOW_BITS-1:0] any_time();
      return NOW_BITS'({$urandom(), $urandom()});
   endfunction

   function automatic logic [OWNER_BITS-1:0] any_owner();
      return OWNER_BITS'($urandom_range(16'hFFFF, 1));
   endfunction

   // Mostly the rightful owner, sometimes nobody or a stranger.
   function automatic logic [OWNER_BITS-1:0] pick_owner(logic [OWNER_BITS-1:0] who);
      case ($urandom_range(9))
         0:       return '0;
         1:       return OWNER_BITS'($urandom_range(16'hFFFF, 0));
         default: return who;
      endcase
   endfunction

   // Durations near and on both limits, just outside them, or anywhere.
   function automatic logic [DUR_BITS-1:0] pick_duration();
      logic [DUR_BITS-1:0] top;
      top = (dur_ceiling - dur_floor > 32'd5000) ? dur_floor + 32'd5000 : dur_ceiling;
      case ($urandom_range(9))
         0:       return $urandom();
         1:       return dur_floor;
         2:       return dur_ceiling;
         3:       return dur_floor - 1'b1;
         4:       return dur_ceiling + 1'b1;
         default: return (dur_floor > dur_ceiling) ? $urandom()
                                                   : $urandom_range(top, dur_floor);
      endcase
   endfunction

   // Advance targets around the deadline: the same time, a step back, short
   // of the deadline, right on it, or past it.
   function automatic logic [NOW_BITS-1:0] pick_time();
      logic [DUR_BITS-1:0] span;
      span = (timer_mode == MODE_RUNNING) ? DUR_BITS'(deadline_ms - clock_ms) : time_left;
      case ($urandom_range(7))
         0: return clock_ms;
         1: return (clock_ms > 48'd1000) ? clock_ms - NOW_BITS'($urandom_range(1000, 1))
                                         : '0;
         2: return add_saturate(clock_ms, {1'b0, span});
         3: return add_saturate(clock_ms, {1'b0, span} + 33'($urandom_range(1000, 1)));
         default: return add_saturate(clock_ms, 33'($urandom_range(span, 0)));
      endcase
   endfunction

   // Sends one command transaction and records what must come back for it.
   // The valid stays high on return so back-to-back commands need no gap.
   task automatic send_command(logic [2:0] op, logic [NOW_BITS-1:0] now,
                               logic [OWNER_BITS-1:0] who, logic [DUR_BITS-1:0] dur);
      cmd_type c;
      c.op          = op;
      c.now_ms      = now;
      c.owner_id    = who;
      c.duration_ms = dur;
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_BITS'(c);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(timer_step(c));
      sent_count++;
   endtask

   // Holds the sender off until every expected result has arrived.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both duration limits, only ever with nothing in flight.
   task automatic write_limits(logic [DUR_BITS-1:0] lo, logic [DUR_BITS-1:0] hi);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= CSR_MIN_DURATION;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_MAX_DURATION;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we      <= 1'b0;
      dur_floor   = lo;
      dur_ceiling = hi;
   endtask

   // Walks the timer back to ready by the legal path from wherever it is.
   task automatic bring_to_ready();
      if (timer_mode == MODE_PAUSED)
         send_command(OP_RESUME, any_time(), timer_owner, $urandom());
      if (timer_mode == MODE_RUNNING)
         send_command(OP_ADVANCE, deadline_ms, any_owner(), $urandom());
      if (timer_mode == MODE_EXPIRED)
         send_command(OP_ACK, any_time(), OWNER_BITS'($urandom_range(16'hFFFF, 0)),
                      $urandom());
   endtask

   // A command with every field random, spare opcodes included.
   task automatic send_noise();
      send_command(3'($urandom_range(7)), $urandom_range(1) ? any_time() : pick_time(),
                   OWNER_BITS'($urandom_range(16'hFFFF, 0)), $urandom());
   endtask

   // One life of the timer: a start, a few random commands, mostly by the
   // owner, then usually a walk back to ready.
   task automatic timer_episode();
      logic [OWNER_BITS-1:0] who;
      int                    steps;
      if ($urandom_range(3) != 0) bring_to_ready();
      who = any_owner();
      send_command(OP_START, any_time(), who, pick_duration());
      steps = $urandom_range(8, 1);
      repeat (steps) begin
         case ($urandom_range(9))
            0, 1, 2, 3: send_command(OP_ADVANCE, pick_time(), any_owner(), $urandom());
            4:          send_command(OP_PAUSE, any_time(), pick_owner(who), $urandom());
            5:          send_command(OP_RESUME, any_time(), pick_owner(who), $urandom());
            6:          send_command(OP_SET_REM, any_time(), pick_owner(who), pick_duration());
            7:          send_command(OP_ACK, any_time(), pick_owner(who), $urandom());
            default:    send_noise();
         endcase
      end
      if ($urandom_range(3) != 0) bring_to_ready();
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Every opcode, every rejection, field extremes, and the start that comes
   // before any time has been seen, under the limits left by reset.
   task automatic test_directed_commands();
      gap_pct   = 0;
      stall_pct = 0;
      send_command(OP_SPARE_LO, TIME_TOP, 16'hFFFF, 32'hFFFF_FFFF);
      send_command(OP_SPARE_HI, '0, '0, '0);
      send_command(OP_ACK, '0, 16'h0001, '0);
      send_command(OP_PAUSE, '0, 16'h0001, '0);
      send_command(OP_RESUME, '0, 16'h0001, '0);
      send_command(OP_SET_REM, '0, 16'h0001, 32'd7);
      send_command(OP_START, '0, '0, 32'd5);
      send_command(OP_START, '0, 16'hFFFF, 32'd0);
      // Start with no time seen yet: the deadline counts from zero.
      send_command(OP_START, TIME_TOP, 16'hFFFF, 32'd5);
      send_command(OP_PAUSE, '0, '0, '0);
      send_command(OP_PAUSE, '0, 16'h0001, '0);
      send_command(OP_PAUSE, '0, 16'hFFFF, '0);
      send_command(OP_START, '0, 16'hFFFF, 32'd9);
      send_command(OP_SET_REM, '0, 16'h0001, 32'd9);
      send_command(OP_SET_REM, '0, 16'hFFFF, 32'd0);
      send_command(OP_SET_REM, '0, 16'hFFFF, 32'hFFFF_FFFF);
      send_command(OP_RESUME, '0, '0, '0);
      send_command(OP_RESUME, '0, 16'hFFFF, '0);
      // The first advance is taken as it is; later ones may not go back.
      send_command(OP_ADVANCE, 48'd1000, 16'h0001, '0);
      send_command(OP_ADVANCE, 48'd999, 16'h0001, '0);
      send_command(OP_ADVANCE, 48'd1000, 16'h0001, '0);
      send_command(OP_ADVANCE, 48'hFFFF_FFFF, 16'h0001, '0);
      send_command(OP_ACK, '0, '0, '0);
      send_command(OP_ACK, '0, 16'hFFFF, '0);
      send_command(OP_ADVANCE, 48'h1_0000_0000, '0, '0);
   endtask

   // Starts and set-remaining commands on and around both limits, for a point
   // range at each end of the scale, an empty range and the full range.
   task automatic test_duration_limits();
      logic [DUR_BITS-1:0] floors   [4];
      logic [DUR_BITS-1:0] ceilings [4];
      logic [DUR_BITS-1:0] tries    [6];
      floors   = '{32'd0, 32'hFFFF_FFFF, 32'd10, 32'd0};
      ceilings = '{32'd0, 32'hFFFF_FFFF, 32'd5, 32'hFFFF_FFFF};
      for (int i = 0; i < 4; i++) begin
         write_limits(floors[i], ceilings[i]);
         tries = '{floors[i] - 1'b1, floors[i], ceilings[i], ceilings[i] + 1'b1,
                   32'd0, 32'hFFFF_FFFF};
         foreach (tries[j]) begin
            send_command(OP_START, any_time(), any_owner(), tries[j]);
            if (timer_mode == MODE_RUNNING) begin
               send_command(OP_PAUSE, any_time(), timer_owner, $urandom());
               send_command(OP_SET_REM, any_time(), timer_owner, tries[j] ^ 32'd1);
            end
            bring_to_ready();
         end
      end
   endtask

   // Mostly well-formed timer lives with random content, some pure noise.
   task automatic test_random_traffic(int gap, int stall,
                                      logic [DUR_BITS-1:0] lo, logic [DUR_BITS-1:0] hi);
      int first;
      write_limits(lo, hi);
      gap_pct   = gap;
      stall_pct = stall;
      first     = sent_count;
      while (sent_count - first < RANDOM_PER_PHASE) begin
         if ($urandom_range(7) == 0) send_noise();
         else timer_episode();
      end
   endtask

   // Deadlines that clamp at the top of the time range, a resume that reaches the
   // top again, and a start at the very top that expires on the next advance.
   task automatic test_time_ceiling();
      write_limits(MIN_DURATION_RESET, MAX_DURATION_RESET);
      gap_pct   = 37;
      stall_pct = 37;
      bring_to_ready();
      send_command(OP_ADVANCE, TIME_TOP - 48'd10, any_owner(), $urandom());
      send_command(OP_START, any_time(), 16'h8001, 32'hFFFF_FFFF);
      send_command(OP_ADVANCE, TIME_TOP - 48'd1, any_owner(), $urandom());
      send_command(OP_PAUSE, any_time(), 16'h8001, $urandom());
      send_command(OP_RESUME, any_time(), 16'h8001, $urandom());
      send_command(OP_ADVANCE, TIME_TOP, any_owner(), $urandom());
      send_command(OP_ADVANCE, '0, any_owner(), $urandom());
      send_command(OP_ACK, any_time(), '0, $urandom());
      send_command(OP_START, any_time(), 16'h0001, 32'd1);
      send_command(OP_ADVANCE, TIME_TOP, any_owner(), $urandom());
      send_command(OP_ACK, any_time(), 16'h0001, $urandom());
   endtask

   // ------------------------------------------------------------------------
   // Sequence of the run
   // ------------------------------------------------------------------------
   initial begin
      // Synchronous reset, once, at the start.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed_commands();
      test_duration_limits();

      // Random phases: no idling, sender gaps, receiver stalls, then both.
      // Each phase also moves the duration limits.
      test_random_traffic(0, 0, MIN_DURATION_RESET, MAX_DURATION_RESET);
      test_random_traffic(47, 0, 32'd0, 32'h0000_FFFF);
      test_random_traffic(0, 47, 32'd100, 32'd100000);
      test_random_traffic(37, 37, 32'd0, 32'hFFFF_FFFF);

      test_time_ceiling();

      drain_results();
      if (pending_results.size() != 0) begin
         $display("%0d results never arrived", pending_results.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/pct_pkg.sv
rtl/pct_cmd_stage.sv
rtl/pct_engine.sv
rtl/pct_rsp_stage.sv
rtl/pausable_countdown_timer.sv
rtl/pct_checker.sv
bench/tb.sv
